// File: src/bpk_pkg.sv
// Package for the fixed-width bit packer: item types, widths and register indexes.
// No dependencies; imported by every module under src.
`timescale 1ns / 1ps
`default_nettype none

package bpk_pkg;

    localparam int WORD_BITS  = 64;
    localparam int WIDTH_W    = 6;   // bits_per_entry
    localparam int FREE_W     = 7;   // 0..64 free positions
    localparam int TOTAL_W    = 32;  // total_elements
    localparam int COUNT_W    = 33;  // words_emitted
    localparam int VALUE_W    = 63;
    localparam int PROD_W     = TOTAL_W + WIDTH_W;
    localparam int CFG_IDX_W  = 1;
    localparam int CFG_DATA_W = 32;

    localparam logic [WIDTH_W-1:0] BPE_RESET = WIDTH_W'(8);

    // register indexes
    localparam logic [CFG_IDX_W-1:0] REG_BITS_PER_ENTRY = 1'b0;
    localparam logic [CFG_IDX_W-1:0] REG_TOTAL_ELEMENTS = 1'b1;

    // item codes
    localparam logic FUNC_APPEND = 1'b0;
    localparam logic FUNC_FLUSH  = 1'b1;

    typedef struct packed {
        logic               func;
        logic [VALUE_W-1:0] value;
    } in_item_t;

    typedef struct packed {
        logic [WORD_BITS-1:0] word;
        logic                 has_word;
        logic                 last;
        logic                 count_mismatch;
    } out_item_t;

    typedef struct packed {
        logic [WIDTH_W-1:0] bits_per_entry;
        logic [TOTAL_W-1:0] total_elements;
    } cfg_t;

    // result handed from the packing stage to the output buffer
    typedef struct packed {
        logic      valid;
        out_item_t item;
    } res_t;

endpackage

`default_nettype wire

// File: src/bpk_pack.sv
// Packing datapath: accumulator, free-bit count, word counter and flush check.
// Depends on bpk_pkg.
`timescale 1ns / 1ps
`default_nettype none

module bpk_pack (
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             take,
    input  wire bpk_pkg::in_item_t item,
    input  wire bpk_pkg::cfg_t    cfg,
    output bpk_pkg::res_t         res
);
    import bpk_pkg::*;

    logic [WORD_BITS-1:0] acc_reg,   acc_next;
    logic [FREE_W-1:0]    free_reg,  free_next;
    logic [COUNT_W-1:0]   count_reg, count_next;

    logic [FREE_W-1:0]    w7;
    logic [WORD_BITS-1:0] mask;
    logic [WORD_BITS-1:0] v;
    logic                 fits;      // value leaves word partly filled
    logic [FREE_W-1:0]    sh_left;
    logic [FREE_W-1:0]    rest;
    logic [FREE_W-1:0]    low_sh;
    logic [WORD_BITS-1:0] merged;
    logic [PROD_W-1:0]    total;
    logic [COUNT_W-1:0]   expected;
    logic                 has;
    logic [COUNT_W-1:0]   count_flush;

    assign w7      = {1'b0, cfg.bits_per_entry};
    assign mask    = ~({WORD_BITS{1'b1}} << cfg.bits_per_entry);
    assign v       = {1'b0, item.value} & mask;
    assign fits    = w7 < free_reg;
    assign sh_left = free_reg - w7;
    assign rest    = w7 - free_reg;
    assign low_sh  = FREE_W'(WORD_BITS) - rest;
    assign merged  = acc_reg | (fits ? (v << sh_left[WIDTH_W-1:0])
                                     : (v >> rest[WIDTH_W-1:0]));

    // expected words = ceil(total_elements * width / 64)
    assign total    = PROD_W'(cfg.total_elements) * PROD_W'(cfg.bits_per_entry);
    assign expected = COUNT_W'(total[PROD_W-1:6]) + COUNT_W'(|total[5:0]);

    assign has         = free_reg != FREE_W'(WORD_BITS);
    assign count_flush = count_reg + COUNT_W'(has);

    always_comb
    begin
        acc_next   = acc_reg;
        free_next  = free_reg;
        count_next = count_reg;
        res        = '0;
        if (take)
        begin
            if (item.func == FUNC_FLUSH)
            begin
                res.valid               = 1'b1;
                res.item.word           = has ? acc_reg : '0;
                res.item.has_word       = has;
                res.item.last           = 1'b1;
                res.item.count_mismatch = count_flush != expected;
                acc_next   = '0;
                free_next  = FREE_W'(WORD_BITS);
                count_next = '0;
            end
            else if (cfg.bits_per_entry != '0)
            begin
                if (fits)
                begin
                    acc_next  = merged;
                    free_next = sh_left;
                end
                else
                begin
                    // word full; any spill goes to the top of the next word
                    res.valid         = 1'b1;
                    res.item.word     = merged;
                    res.item.has_word = 1'b1;
                    count_next        = count_reg + COUNT_W'(1);
                    if (rest == '0)
                    begin
                        acc_next  = '0;
                        free_next = FREE_W'(WORD_BITS);
                    end
                    else
                    begin
                        acc_next  = v << low_sh[WIDTH_W-1:0];
                        free_next = low_sh;
                    end
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            acc_reg   <= '0;
            free_reg  <= FREE_W'(WORD_BITS);
            count_reg <= '0;
        end
        else
        begin
            acc_reg   <= acc_next;
            free_reg  <= free_next;
            count_reg <= count_next;
        end
    end

endmodule

`default_nettype wire

// File: src/bpk_out_buf.sv
// Two-entry output buffer: head register drives the port, spare catches a
// result while the head is stalled. Depends on bpk_pkg.
`timescale 1ns / 1ps
`default_nettype none

module bpk_out_buf (
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire bpk_pkg::res_t    res,
    output logic                  full,
    output logic                  out_valid,
    input  wire logic             out_stall,
    output bpk_pkg::out_item_t    out_data
);
    import bpk_pkg::*;

    out_item_t head_reg,  head_next;
    out_item_t spare_reg, spare_next;
    logic      hv_reg,    hv_next;
    logic      sv_reg,    sv_next;
    logic      pop;

    assign pop = hv_reg && !out_stall;

    always_comb
    begin
        head_next  = head_reg;
        spare_next = spare_reg;
        hv_next    = hv_reg;
        sv_next    = sv_reg;
        if (pop)
        begin
            if (sv_reg)
            begin
                head_next = spare_reg;
                sv_next   = 1'b0;
            end
            else
            begin
                hv_next = 1'b0;
            end
        end
        if (res.valid)
        begin
            if (!hv_next)
            begin
                head_next = res.item;
                hv_next   = 1'b1;
            end
            else
            begin
                spare_next = res.item;
                sv_next    = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            hv_reg <= 1'b0;
            sv_reg <= 1'b0;
        end
        else
        begin
            hv_reg <= hv_next;
            sv_reg <= sv_next;
        end
    end

    always_ff @(posedge clk)
    begin
        head_reg  <= head_next;
        spare_reg <= spare_next;
    end

    assign full      = sv_reg;
    assign out_valid = hv_reg;
    assign out_data  = head_reg;

endmodule

`default_nettype wire

// File: src/fixed_width_bit_packer_core.sv
// Top level of the fixed-width bit packer: configuration registers, packing
// stage and output buffer. Depends on bpk_pkg, bpk_pack and bpk_out_buf.
`timescale 1ns / 1ps
`default_nettype none

// Packs values of bits_per_entry bits (1..63) most-significant-first into
// 64-bit words and hands each word out as soon as it is full. One input
// transfer is taken every clock cycle while in_stall is low: the
// shift-and-merge into the accumulator is combinational, so the rate is one
// item per cycle, and each result is registered into the output buffer.
// Results sit in a two-entry output buffer; in_stall rises only when both
// entries are occupied, which a downstream stall of a single cycle can cause
// when results arrive back to back. A flush item (func = 1) always gives one
// result marked last: the
// partly filled word left-aligned and zero-padded (has_word 1), or an empty
// result (has_word 0) if nothing is pending. Its count_mismatch is 1 when the
// words emitted in the stream, flush word included, differ from
// ceil(total_elements * bits_per_entry / 64). Flush restarts the stream; the
// registers keep their values. A width of zero appends nothing. Registers
// are written through cfg_we / cfg_index / cfg_data (0 = bits_per_entry in
// bits 5:0, 1 = total_elements) and must only change while the block is idle.
module fixed_width_bit_packer_core (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic                          in_valid,
    output logic                               in_stall,
    input  wire bpk_pkg::in_item_t             in_data,
    output logic                               out_valid,
    input  wire logic                          out_stall,
    output bpk_pkg::out_item_t                 out_data,
    input  wire logic                          cfg_we,
    input  wire logic [bpk_pkg::CFG_IDX_W-1:0] cfg_index,
    input  wire logic [bpk_pkg::CFG_DATA_W-1:0] cfg_data
);
    import bpk_pkg::*;

    logic [WIDTH_W-1:0] bpe_reg;
    logic [TOTAL_W-1:0] total_reg;
    cfg_t               cfg;
    res_t               res;
    logic               buf_full;
    logic               take;

    // configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            bpe_reg   <= BPE_RESET;
            total_reg <= '0;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                REG_BITS_PER_ENTRY: bpe_reg   <= cfg_data[WIDTH_W-1:0];
                REG_TOTAL_ELEMENTS: total_reg <= cfg_data[TOTAL_W-1:0];
                default:            ;
            endcase
        end
    end

    assign cfg.bits_per_entry = bpe_reg;
    assign cfg.total_elements = total_reg;

    // stall depends only on registered buffer state
    assign in_stall = buf_full;
    assign take     = in_valid && !buf_full;

    bpk_pack u_pack (
        .clk   (clk),
        .rst_n (rst_n),
        .take  (take),
        .item  (in_data),
        .cfg   (cfg),
        .res   (res)
    );

    bpk_out_buf u_out_buf (
        .clk       (clk),
        .rst_n     (rst_n),
        .res       (res),
        .full      (buf_full),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .out_data  (out_data)
    );

endmodule

`default_nettype wire

// File: tb/tb_fixed_width_bit_packer_core.sv
// Self-checking testbench for fixed_width_bit_packer_core: a directed table, then
// random streams, each checked against a cycle-free predictor of the packer.
// Depends on bpk_pkg and the RTL under src; reads no files.
`timescale 1ns / 1ps

module tb_fixed_width_bit_packer_core;

    import bpk_pkg::*;

    localparam int RANDOM_ITEMS = 1830;
    localparam int SETTLE_CYCLES = 3;   // registered output buffer, plus margin

    typedef enum logic { ROW_CFG, ROW_ITEM } row_kind_t;

    // One row of the directed table: a register write or an input transfer.
    // Rows marked typed carry a result worked out by hand; the others are
    // left to the predictor.
    typedef struct {
        row_kind_t               kind;
        logic [CFG_IDX_W-1:0]    idx;
        logic [CFG_DATA_W-1:0]   data;
        in_item_t                item;
        bit                      typed;
        out_item_t               want;
    } stim_row_t;

    logic                  clk = 1'b0;
    logic                  rst_n = 1'b0;
    logic                  in_valid = 1'b0;
    logic                  in_stall;
    in_item_t              in_data = '0;
    logic                  out_valid;
    logic                  out_stall = 1'b0;
    out_item_t             out_data;
    logic                  cfg_we = 1'b0;
    logic [CFG_IDX_W-1:0]  cfg_index = '0;
    logic [CFG_DATA_W-1:0] cfg_data = '0;

    // predictor state and its copy of the registers
    logic [WORD_BITS-1:0]  acc_word;
    int                    acc_free;
    logic [COUNT_W-1:0]    words_out;
    logic [WIDTH_W-1:0]    width_cfg;
    logic [TOTAL_W-1:0]    total_cfg;

    out_item_t             pending_words[$];
    stim_row_t             stim_rows[$];
    int                    fail_count = 0;
    int                    values_sent = 0;
    bit                    no_gaps = 1'b0;

    fixed_width_bit_packer_core dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .in_data   (in_data),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .out_data  (out_data),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    always #5 clk = ~clk;

    // Overall guard: far beyond the slowest legal run.
    initial
    begin
        #10_000_000;
        $display("tb_fixed_width_bit_packer_core failed");
        $finish;
    end

    // ------------------------------------------------------------------
    // Predictor
    // ------------------------------------------------------------------

    // Works out the result of one accepted transfer, if any, and moves the
    // stream state on. Values go in most-significant-first; a value that
    // overruns the free positions is split over two words.
    function automatic bit pack_predict(input in_item_t it, output out_item_t res);
        int                   w;
        int                   rest;
        logic [WORD_BITS-1:0] v;
        logic [WORD_BITS-1:0] full;
        logic [PROD_W-1:0]    prod;
        logic [COUNT_W-1:0]   need;
        bit                   has;
        w = int'(width_cfg);
        res = '0;
        if (it.func == FUNC_FLUSH)
        begin
            // ceil(total * width / 64), the flush word counted first
            prod = PROD_W'(total_cfg) * PROD_W'(width_cfg);
            need = COUNT_W'(prod >> 6) + ((prod[5:0] != '0) ? COUNT_W'(1) : COUNT_W'(0));
            has = (acc_free < WORD_BITS);
            if (has)
                words_out = words_out + COUNT_W'(1);
            res.word = has ? acc_word : '0;
            res.has_word = has;
            res.last = 1'b1;
            res.count_mismatch = (words_out != need);
            acc_word = '0;
            acc_free = WORD_BITS;
            words_out = '0;
            return 1'b1;
        end
        // zero width appends nothing
        if (w == 0)
            return 1'b0;
        v = {1'b0, it.value} & ((64'd1 << w) - 64'd1);
        if (w < acc_free)
        begin
            acc_word = acc_word | (v << (acc_free - w));
            acc_free = acc_free - w;
            return 1'b0;
        end
        if (w == acc_free)
        begin
            full = acc_word | v;
            acc_word = '0;
            acc_free = WORD_BITS;
        end
        else
        begin
            rest = w - acc_free;
            full = acc_word | (v >> rest);
            acc_word = v << (WORD_BITS - rest);
            acc_free = WORD_BITS - rest;
        end
        words_out = words_out + COUNT_W'(1);
        res.word = full;
        res.has_word = 1'b1;
        return 1'b1;
    endfunction

    // ------------------------------------------------------------------
    // Checking
    // ------------------------------------------------------------------

    task automatic report_mismatch(input string msg);
        $display("%0t ERROR %s", $time, msg);
        fail_count++;
    endtask

    // Outputs are sampled at the falling edge: a transfer seen there is the
    // one that happens at the next rising edge, since nothing moves between.
    initial
    begin
        out_item_t want;
        forever
        begin
            @(negedge clk);
            if (rst_n && out_valid && !out_stall)
            begin
                if (pending_words.size() == 0)
                    report_mismatch($sformatf("unexpected result word=%h", out_data.word));
                else
                begin
                    want = pending_words.pop_front();
                    if (out_data.word !== want.word)
                        report_mismatch($sformatf("word %h, wanted %h",
                                                  out_data.word, want.word));
                    if (out_data.has_word !== want.has_word)
                        report_mismatch($sformatf("has_word %b, wanted %b",
                                                  out_data.has_word, want.has_word));
                    if (out_data.last !== want.last)
                        report_mismatch($sformatf("last %b, wanted %b",
                                                  out_data.last, want.last));
                    if (out_data.count_mismatch !== want.count_mismatch)
                        report_mismatch($sformatf("count_mismatch %b, wanted %b",
                                                  out_data.count_mismatch,
                                                  want.count_mismatch));
                end
            end
        end
    end

    // ------------------------------------------------------------------
    // Downstream stall: short bursts mostly, the odd long one, and quiet
    // stretches with no stall at all. Even a single stall cycle fills the
    // output buffer when results come back to back, and pushes back on
    // in_stall.
    // ------------------------------------------------------------------

    initial
    begin
        bit quiet;
        int r;
        int len;
        forever
        begin
            quiet = ($urandom_range(0, 9) == 0);
            repeat ($urandom_range(1, quiet ? 200 : 8)) @(posedge clk);
            if (!quiet)
            begin
                r = $urandom_range(0, 19);
                if (r < 10)
                    len = $urandom_range(1, 2);
                else if (r < 17)
                    len = $urandom_range(3, 6);
                else
                    len = $urandom_range(10, 50);
                out_stall <= 1'b1;
                repeat (len) @(posedge clk);
                out_stall <= 1'b0;
            end
        end
    end

    // ------------------------------------------------------------------
    // Sender side
    // ------------------------------------------------------------------

    function automatic int pick_gap();
        int r;
        if (no_gaps)
            return 0;
        r = $urandom_range(0, 19);
        if (r < 8)
            return 0;
        if (r < 17)
            return $urandom_range(1, 3);
        if (r < 19)
            return $urandom_range(4, 10);
        return $urandom_range(20, 60);
    endfunction

    function automatic logic [VALUE_W-1:0] rand_value();
        case ($urandom_range(0, 9)) inside
            0:       return '0;
            1, 2:    return '1;
            default: return VALUE_W'({$urandom(), $urandom()});
        endcase
    endfunction

    // Presents one item after a random gap and holds it until the transfer;
    // in_stall is sampled at the falling edge before the deciding rising edge.
    // On return the caller stands at the rising edge of the transfer.
    task automatic send_item(input in_item_t it, input bit typed, input out_item_t want);
        int        gap;
        bit        held;
        bit        got;
        out_item_t res;
        gap = pick_gap();
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid <= 1'b1;
        in_data <= it;
        do
        begin
            @(negedge clk);
            held = in_stall;
            @(posedge clk);
        end
        while (held);
        if (it.func == FUNC_FLUSH || width_cfg != '0)
            values_sent++;
        got = pack_predict(it, res);
        if (typed)
            pending_words.push_back(want);
        else if (got)
            pending_words.push_back(res);
    endtask

    // Lets every expected result out, then waits out the settle margin for any
    // item still in the pipe that gives no result.
    task automatic drain_results();
        in_valid <= 1'b0;
        while (pending_words.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    // Only called with the block idle.
    task automatic write_register(input logic [CFG_IDX_W-1:0] idx,
                                  input logic [CFG_DATA_W-1:0] data);
        cfg_we <= 1'b1;
        cfg_index <= idx;
        cfg_data <= data;
        @(posedge clk);
        cfg_we <= 1'b0;
        @(posedge clk);
        if (idx == REG_BITS_PER_ENTRY)
            width_cfg = data[WIDTH_W-1:0];
        else
            total_cfg = data[TOTAL_W-1:0];
    endtask

    // ------------------------------------------------------------------
    // Directed table builders
    // ------------------------------------------------------------------

    task automatic add_cfg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
        stim_row_t row;
        row = '{kind: ROW_CFG, idx: idx, data: data, item: '0, typed: 1'b0, want: '0};
        stim_rows.push_back(row);
    endtask

    task automatic add_item(input logic func, input logic [VALUE_W-1:0] value);
        stim_row_t row;
        row = '{kind: ROW_ITEM, idx: '0, data: '0, item: '{func, value},
                typed: 1'b0, want: '0};
        stim_rows.push_back(row);
    endtask

    task automatic add_checked(input logic func, input logic [VALUE_W-1:0] value,
                               input logic [WORD_BITS-1:0] word, input logic has,
                               input logic last, input logic mism);
        stim_row_t row;
        row = '{kind: ROW_ITEM, idx: '0, data: '0, item: '{func, value},
                typed: 1'b1, want: '{word, has, last, mism}};
        stim_rows.push_back(row);
    endtask

    // ------------------------------------------------------------------
    // Main sequence
    // ------------------------------------------------------------------

    initial
    begin
        logic [VALUE_W-1:0]    ones;
        logic [WIDTH_W-1:0]    w;
        logic [CFG_DATA_W-1:0] data;
        logic [TOTAL_W-1:0]    tot;
        int                    n;
        int                    r;
        int                    phase;
        out_item_t             none;

        ones = '1;
        none = '0;
        acc_word = '0;
        acc_free = WORD_BITS;
        words_out = '0;
        width_cfg = BPE_RESET;
        total_cfg = '0;

        // Reset defaults: 8-bit entries, no elements expected.
        // Flush straight after reset: empty result, counts agree.
        add_checked(FUNC_FLUSH, ones, 64'h0, 1'b0, 1'b1, 1'b0);
        // Eight bytes fill one word exactly; high value bits are masked off.
        add_item(FUNC_APPEND, ones);
        repeat (6) add_item(FUNC_APPEND, '0);
        add_checked(FUNC_APPEND, 63'h5A5A_5A5A_5A5A_5A01,
                    64'hFF00_0000_0000_0001, 1'b1, 1'b0, 1'b0);
        // Nothing pending, but one word went out against none expected.
        add_checked(FUNC_FLUSH, '0, 64'h0, 1'b0, 1'b1, 1'b1);
        // Widest entries: partial word on flush, then a value split over two words.
        add_cfg(REG_BITS_PER_ENTRY, 32'hFFFF_FFFF);
        add_cfg(REG_TOTAL_ELEMENTS, 32'h0000_0001);
        add_item(FUNC_APPEND, ones);
        add_checked(FUNC_FLUSH, '0, 64'hFFFF_FFFF_FFFF_FFFE, 1'b1, 1'b1, 1'b0);
        add_item(FUNC_APPEND, ones);
        add_checked(FUNC_APPEND, ones, 64'hFFFF_FFFF_FFFF_FFFF, 1'b1, 1'b0, 1'b0);
        add_checked(FUNC_FLUSH, ones, 64'hFFFF_FFFF_FFFF_FFFC, 1'b1, 1'b1, 1'b1);
        // Single-bit entries against the largest element count.
        add_cfg(REG_BITS_PER_ENTRY, 32'hFFFF_FFC1);
        add_cfg(REG_TOTAL_ELEMENTS, 32'hFFFF_FFFF);
        add_item(FUNC_APPEND, 63'h1);
        add_item(FUNC_APPEND, '0);
        add_checked(FUNC_FLUSH, '0, 64'h8000_0000_0000_0000, 1'b1, 1'b1, 1'b1);
        // Zero width appends nothing; zero words expected and none sent.
        add_cfg(REG_BITS_PER_ENTRY, 32'hFFFF_FFC0);
        add_cfg(REG_TOTAL_ELEMENTS, 32'h0000_0000);
        add_item(FUNC_APPEND, ones);
        add_checked(FUNC_FLUSH, '0, 64'h0, 1'b0, 1'b1, 1'b0);
        // An odd width left to the predictor.
        add_cfg(REG_BITS_PER_ENTRY, 32'h0000_000D);
        add_cfg(REG_TOTAL_ELEMENTS, 32'h0000_0006);
        repeat (5) add_item(FUNC_APPEND, 63'h0000_0000_0000_1ABC);
        add_item(FUNC_FLUSH, '0);

        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (stim_rows[i])
        begin
            if (stim_rows[i].kind == ROW_CFG)
            begin
                drain_results();
                write_register(stim_rows[i].idx, stim_rows[i].data);
            end
            else
                send_item(stim_rows[i].item, stim_rows[i].typed, stim_rows[i].want);
        end

        // Random streams: mostly a fresh width and count, a run of values,
        // then a flush. Now and then a flush lands mid-stream, a stream is
        // left open across a register change, or the count is off by one.
        values_sent = 0;
        phase = 0;
        while (values_sent < RANDOM_ITEMS)
        begin
            no_gaps = ($urandom_range(0, 3) == 0);
            r = $urandom_range(0, 9);
            if (r < 7)
                n = $urandom_range(0, 40);
            else if (r < 9)
                n = $urandom_range(41, 150);
            else
                n = $urandom_range(151, 400);
            if (phase == 0 || $urandom_range(0, 9) != 0)
            begin
                drain_results();
                case ($urandom_range(0, 9))
                    0:       w = '0;
                    1:       w = 6'd1;
                    2:       w = 6'd63;
                    default: w = WIDTH_W'($urandom_range(1, 62));
                endcase
                data = $urandom();
                data[WIDTH_W-1:0] = w;
                write_register(REG_BITS_PER_ENTRY, data);
                if (w == '0)
                    n = n % 8;
                r = $urandom_range(0, 19);
                if (r < 10)
                    tot = TOTAL_W'(n);
                else if (r < 13)
                    tot = $urandom();
                else if (r < 15)
                    tot = '0;
                else if (r < 17)
                    tot = '1;
                else
                    tot = TOTAL_W'(n + (($urandom_range(0, 1) != 0) ? 1 : -1));
                write_register(REG_TOTAL_ELEMENTS, tot);
            end
            else if (width_cfg == '0)
                n = n % 8;
            for (int k = 0; k < n; k++)
            begin
                // the sender waits for the output to empty mid-stream
                if ((phase == 2 && k == n / 2) || $urandom_range(0, 49) == 0)
                    drain_results();
                if ($urandom_range(0, 32) == 0)
                    send_item('{FUNC_FLUSH, rand_value()}, 1'b0, none);
                else
                    send_item('{FUNC_APPEND, rand_value()}, 1'b0, none);
            end
            if ($urandom_range(0, 9) != 0)
                send_item('{FUNC_FLUSH, rand_value()}, 1'b0, none);
            phase++;
        end

        // Close the last stream so any bits still held come out.
        send_item('{FUNC_FLUSH, '0}, 1'b0, none);
        drain_results();
        repeat (10) @(posedge clk);
        if (fail_count == 0)
            $display("tb_fixed_width_bit_packer_core passed");
        else
            $display("tb_fixed_width_bit_packer_core failed");
        $finish;
    end

endmodule

// File: fixed_width_bit_packer_core.f
src/bpk_pkg.sv
src/bpk_pack.sv
src/bpk_out_buf.sv
src/fixed_width_bit_packer_core.sv
tb/tb_fixed_width_bit_packer_core.sv
